// File: hw/rtl/rqcvg_pkg.sv
// rqcvg_pkg: shared types, constants and lookup functions of the vertex generator
// used by rqcvg_ctrl, rqcvg_dp and rotated_quad_cube_vertex_gen_top
package rqcvg_pkg;

  localparam int VW = 36;               // rotated coordinate width
  localparam int ONE_Q14 = 16384;
  localparam logic [15:0] SIN_A = 16'd25736;
  localparam logic [15:0] SIN_B = 16'd10512;
  localparam logic [15:0] SIN_C = 16'd1160;
  localparam logic [3:0] NUM_VEC = 4'd14;   // 8 corners then 6 normals

  // controller to datapath commands
  typedef struct packed {
    logic        load;
    logic        trig_en;
    logic [2:0]  trig_eval;
    logic [1:0]  trig_step;
    logic        rot_load;
    logic        rot_mul;
    logic        rot_acc;
    logic        rot_wr;
    logic [1:0]  rot_stage;
    logic [3:0]  rot_vec;
    logic        emit;
    logic        emit_full;
    logic [2:0]  face;
    logic [1:0]  corner;
    logic [11:0] vidx;
    logic        last;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cube;
    logic out_free;
  } dp_sts_t;

  // negate mask {z,y,x} of a cube corner
  function automatic logic [2:0] corner_neg(input logic [2:0] i);
    logic [2:0] m;
    case (i)
      3'd0: m = 3'b011;
      3'd1: m = 3'b010;
      3'd2: m = 3'b000;
      3'd3: m = 3'b001;
      3'd4: m = 3'b110;
      3'd5: m = 3'b111;
      3'd6: m = 3'b101;
      3'd7: m = 3'b100;
      default: m = 3'b000;
    endcase
    return m;
  endfunction

  // corner of face f at position k
  function automatic logic [2:0] face_corner(input logic [2:0] f, input logic [1:0] k);
    logic [11:0] row;
    case (f)
      3'd0: row = {3'd3, 3'd2, 3'd1, 3'd0};
      3'd1: row = {3'd7, 3'd6, 3'd5, 3'd4};
      3'd2: row = {3'd2, 3'd7, 3'd4, 3'd1};
      3'd3: row = {3'd6, 3'd3, 3'd0, 3'd5};
      3'd4: row = {3'd6, 3'd7, 3'd2, 3'd3};
      3'd5: row = {3'd0, 3'd1, 3'd4, 3'd5};
      default: row = 12'd0;
    endcase
    return row[k*3 +: 3];
  endfunction

  // face normal: bit 2 negative, bits 1:0 axis (0 x, 1 y, 2 z)
  function automatic logic [2:0] face_normal(input logic [2:0] f);
    logic [2:0] d;
    case (f)
      3'd0: d = 3'b010;
      3'd1: d = 3'b110;
      3'd2: d = 3'b000;
      3'd3: d = 3'b100;
      3'd4: d = 3'b001;
      3'd5: d = 3'b101;
      default: d = 3'b000;
    endcase
    return d;
  endfunction

endpackage

// File: hw/rtl/rqcvg_dp.sv
// rqcvg_dp: datapath of the vertex generator: item registers, sine unit,
// rotation unit, corner and normal stores, output register; needs rqcvg_pkg
module rqcvg_dp import rqcvg_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  dp_cmd_t      cmd,
  output dp_sts_t      sts,
  input  logic [311:0] in_tdata,
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [199:0] out_tdata,
  output logic         out_tlast,
  output logic         out_tuser
);

  // item registers
  logic               op_r;
  logic signed [31:0] ctr_r [3];
  logic [15:0]        ang_r [3];
  logic [29:0]        half_r [3];
  logic [63:0]        tex_r;
  logic [7:0]         tid_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_tuser;
      ctr_r[0]  <= in_tdata[31:0];
      ctr_r[1]  <= in_tdata[63:32];
      ctr_r[2]  <= in_tdata[95:64];
      ang_r[0]  <= in_tdata[111:96];
      ang_r[1]  <= in_tdata[127:112];
      ang_r[2]  <= in_tdata[143:128];
      half_r[0] <= in_tdata[174:145];
      half_r[1] <= in_tdata[205:176];
      half_r[2] <= in_tuser ? in_tdata[236:207] : 30'd0;
      tex_r     <= in_tdata[300:237];
      tid_r     <= in_tdata[308:301];
    end
  end

  // sine unit: one multiply a step, four steps per value
  logic [1:0]         t_axis;
  logic [15:0]        t_ang;
  logic [14:0]        t_val;
  logic [14:0]        t2_r;
  logic [13:0]        i1_r;
  logic [14:0]        i2_r;
  logic [15:0]        m_a, m_b;
  logic [31:0]        m_p;
  logic [14:0]        y_cap;
  logic signed [16:0] y_sgn;
  logic signed [16:0] s_r [3];
  logic signed [16:0] c_r [3];

  assign t_axis = cmd.trig_eval[2:1];
  assign t_ang  = ang_r[t_axis] + (cmd.trig_eval[0] ? 16'd16384 : 16'd0);
  assign t_val  = t_ang[14] ? (15'd16384 - {1'b0, t_ang[13:0]}) : {1'b0, t_ang[13:0]};

  always_comb begin
    case (cmd.trig_step)
      2'd0: begin m_a = {1'b0, t_val}; m_b = {1'b0, t_val}; end
      2'd1: begin m_a = {1'b0, t2_r};  m_b = SIN_C; end
      2'd2: begin m_a = {1'b0, t2_r};  m_b = {2'b0, i1_r}; end
      default: begin m_a = {1'b0, t_val}; m_b = {1'b0, i2_r}; end
    endcase
  end
  assign m_p   = m_a * m_b;
  assign y_cap = (m_p[31:14] > 18'd16384) ? 15'd16384 : m_p[28:14];
  assign y_sgn = t_ang[15] ? -$signed({2'b0, y_cap}) : $signed({2'b0, y_cap});

  always_ff @(posedge clk) begin
    if (cmd.trig_en) begin
      case (cmd.trig_step)
        2'd0: t2_r <= m_p[28:14];
        2'd1: i1_r <= 14'(SIN_B - m_p[29:14]);
        2'd2: i2_r <= 15'(SIN_A - m_p[29:14]);
        default: begin
          if (cmd.trig_eval[0]) c_r[t_axis] <= y_sgn;
          else s_r[t_axis] <= y_sgn;
        end
      endcase
    end
  end

  // initial vector of the rotation
  logic [2:0]           cneg;
  logic [2:0]           ndir;
  logic signed [VW-1:0] init [3];
  logic signed [VW-1:0] hval;

  assign cneg = corner_neg(cmd.rot_vec[2:0]);
  assign ndir = face_normal(3'(cmd.rot_vec - 4'd8));

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      hval = $signed({{(VW-30){1'b0}}, half_r[a]});
      if (!cmd.rot_vec[3]) begin
        init[a] = cneg[a] ? -hval : hval;
      end else if (ndir[1:0] == 2'(a)) begin
        init[a] = ndir[2] ? -VW'(ONE_Q14) : VW'(ONE_Q14);
      end else begin
        init[a] = '0;
      end
    end
  end

  // rotation unit: four products, then sum and round
  logic signed [VW-1:0]  w_r [3];
  logic signed [VW-1:0]  opa, opb;
  logic signed [16:0]    rs, rc;
  logic signed [VW+16:0] p_r [4];
  logic signed [VW+17:0] sum1, sum2;
  logic signed [VW+17:0] rnd1, rnd2;

  assign rs  = s_r[cmd.rot_stage];
  assign rc  = c_r[cmd.rot_stage];
  assign opa = (cmd.rot_stage == 2'd0) ? w_r[1] : w_r[0];
  assign opb = (cmd.rot_stage == 2'd2) ? w_r[1] : w_r[2];

  always_ff @(posedge clk) begin
    if (cmd.rot_mul) begin
      p_r[0] <= rc * opa;
      p_r[1] <= rs * opb;
      p_r[2] <= rs * opa;
      p_r[3] <= rc * opb;
    end
  end

  assign sum1 = (cmd.rot_stage == 2'd1) ? (VW+18)'(p_r[0]) + (VW+18)'(p_r[1])
                                        : (VW+18)'(p_r[0]) - (VW+18)'(p_r[1]);
  assign sum2 = (cmd.rot_stage == 2'd1) ? (VW+18)'(p_r[3]) - (VW+18)'(p_r[2])
                                        : (VW+18)'(p_r[2]) + (VW+18)'(p_r[3]);
  assign rnd1 = (sum1 + (VW+18)'(8192)) >>> 14;
  assign rnd2 = (sum2 + (VW+18)'(8192)) >>> 14;

  always_ff @(posedge clk) begin
    if (cmd.rot_load) begin
      w_r <= init;
    end else if (cmd.rot_acc) begin
      case (cmd.rot_stage)
        2'd0: begin w_r[1] <= rnd1[VW-1:0]; w_r[2] <= rnd2[VW-1:0]; end
        2'd1: begin w_r[0] <= rnd1[VW-1:0]; w_r[2] <= rnd2[VW-1:0]; end
        default: begin w_r[0] <= rnd1[VW-1:0]; w_r[1] <= rnd2[VW-1:0]; end
      endcase
    end
  end

  // corner and normal stores
  logic signed [VW-1:0] cor_r [8][3];
  logic signed [VW-1:0] nrm_r [6][3];
  logic [2:0]           nsel;

  assign nsel = 3'(cmd.rot_vec - 4'd8);

  always_ff @(posedge clk) begin
    if (cmd.rot_wr) begin
      if (!cmd.rot_vec[3]) cor_r[cmd.rot_vec[2:0]] <= w_r;
      else nrm_r[nsel] <= w_r;
    end
  end

  // vertex assembly
  logic [2:0]  ci;
  logic [31:0] pos [3];
  logic [15:0] nrm [3];
  logic [15:0] tu, tv;

  assign ci = face_corner(cmd.face, cmd.corner);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pos[a] = cor_r[ci][a][31:0] + ctr_r[a];
      if (nrm_r[cmd.face][a] > VW'(ONE_Q14)) nrm[a] = 16'(ONE_Q14);
      else if (nrm_r[cmd.face][a] < -VW'(ONE_Q14)) nrm[a] = 16'(-ONE_Q14);
      else nrm[a] = nrm_r[cmd.face][a][15:0];
    end
  end
  assign tu = (cmd.corner == 2'd1 || cmd.corner == 2'd2) ? tex_r[47:32] : tex_r[15:0];
  assign tv = cmd.corner[1] ? tex_r[63:48] : tex_r[31:16];

  // output register
  logic         ovalid_r, ovalid_nxt;
  logic [199:0] odata_r;
  logic         olast_r, ouser_r;

  assign ovalid_nxt = (cmd.emit || cmd.emit_full) ? 1'b1 : (out_tready ? 1'b0 : ovalid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else ovalid_r <= ovalid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_full) begin
      odata_r <= '0;
      olast_r <= 1'b1;
      ouser_r <= 1'b1;
    end else if (cmd.emit) begin
      odata_r <= {4'd0, cmd.vidx, tid_r, tv, tu, nrm[2], nrm[1], nrm[0],
                  pos[2], pos[1], pos[0]};
      olast_r <= cmd.last;
      ouser_r <= 1'b0;
    end
  end

  assign out_tvalid   = ovalid_r;
  assign out_tdata    = odata_r;
  assign out_tlast    = olast_r;
  assign out_tuser    = ouser_r;
  assign sts.out_free = !ovalid_r || out_tready;
  assign sts.cube     = op_r;

endmodule

// File: hw/rtl/rqcvg_ctrl.sv
// rqcvg_ctrl: sequencer of the vertex generator, capacity register and quad count
// drives rqcvg_dp through dp_cmd_t; needs rqcvg_pkg
module rqcvg_ctrl import rqcvg_pkg::*; #(
  parameter int MAX_QUADS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        cfg_valid,
  input  logic [10:0] cfg_data,
  output dp_cmd_t     cmd,
  input  dp_sts_t     sts
);

  localparam int QB = $clog2(MAX_QUADS + 1);
  localparam int CW = (QB > 12) ? QB : 12;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_FULL  = 3'd2;
  localparam logic [2:0] S_TRIG  = 3'd3;
  localparam logic [2:0] S_ROT   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [3:0]  vi_r, vi_nxt;
  logic [2:0]  sub_r, sub_nxt;
  logic [10:0] cap_r;
  logic [10:0] used_r, used_nxt;
  logic [CW-1:0] need, cap_eff;
  logic        full;
  logic [4:0]  nlast;

  // capacity check
  assign cap_eff = (CW'(cap_r) < CW'(MAX_QUADS)) ? CW'(cap_r) : CW'(MAX_QUADS);
  assign need    = CW'(used_r) + (sts.cube ? CW'(6) : CW'(1));
  assign full    = need > cap_eff;
  assign nlast   = sts.cube ? 5'd23 : 5'd3;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    vi_nxt    = vi_r;
    sub_nxt   = sub_r;
    used_nxt  = used_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.trig_eval = cnt_r[4:2];
    cmd.trig_step = cnt_r[1:0];
    cmd.rot_vec   = vi_r;
    cmd.rot_stage = 2'((sub_r - 3'd1) >> 1);
    cmd.face      = cnt_r[4:2];
    cmd.corner    = cnt_r[1:0];
    cmd.vidx      = {used_r[9:0], 2'b00} + 12'(cnt_r);
    cmd.last      = (cnt_r == nlast);
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_nxt   = '0;
        state_nxt = full ? S_FULL : S_TRIG;
      end
      S_FULL: begin
        if (sts.out_free) begin
          cmd.emit_full = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_TRIG: begin
        cmd.trig_en = 1'b1;
        cnt_nxt     = cnt_r + 5'd1;
        if (cnt_r == 5'd23) begin
          cnt_nxt   = '0;
          vi_nxt    = '0;
          sub_nxt   = '0;
          state_nxt = S_ROT;
        end
      end
      S_ROT: begin
        cmd.rot_load = (sub_r == 3'd0);
        cmd.rot_mul  = sub_r[0];
        cmd.rot_acc  = !sub_r[0] && (sub_r != 3'd0) && (sub_r != 3'd7);
        cmd.rot_wr   = (sub_r == 3'd7);
        sub_nxt      = sub_r + 3'd1;
        if (sub_r == 3'd7) begin
          vi_nxt = vi_r + 4'd1;
          if (vi_r == NUM_VEC - 4'd1) state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cnt_nxt  = cnt_r + 5'd1;
          if (cmd.last) begin
            used_nxt  = used_r + (sts.cube ? 11'd6 : 11'd1);
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      vi_r    <= '0;
      sub_r   <= '0;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      vi_r    <= vi_nxt;
      sub_r   <= sub_nxt;
      used_r  <= used_nxt;
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= 11'd1024;
    else if (cfg_valid) cap_r <= cfg_data;
  end

  // checks
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.emit_full) |-> sts.out_free) else $error("emit while output busy");
  a_check_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |=> (state_r == S_FULL || state_r == S_TRIG))
    else $error("bad state after check");
  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (cnt_r <= nlast)) else $error("emit count overrun");

endmodule

// File: hw/rtl/rotated_quad_cube_vertex_gen_top.sv
// Vertex generator for rotated quads and cubes. One request is taken at a
// time: after acceptance the block runs the capacity check, forms the
// three sines and cosines (one multiply per cycle, four per value), and
// rotates 8 corners and 6 normals through the shared four-multiplier
// rotation unit, then emits 4 (quad) or 24 (cube) vertex beats, one per
// cycle without backpressure. A refused request (store full) yields one
// beat with tuser set.
// top level: rotated_quad_cube_vertex_gen_top; uses rqcvg_pkg, rqcvg_ctrl, rqcvg_dp
module rotated_quad_cube_vertex_gen_top import rqcvg_pkg::*; #(
  parameter int MAX_QUADS = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // center_x, center_y, center_z, angle_x, angle_y, angle_z, size_x, size_y,
  // size_z, tex_rect, texture_id, zero pad
  input  logic [311:0] in_tdata,
  input  logic         in_tuser,   // operation
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v,
  // vertex_texture, vertex_index, zero pad
  output logic [199:0] out_tdata,
  output logic         out_tlast,  // last_vertex
  output logic         out_tuser,  // status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [10:0]  cfg_data    // quad_capacity
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  rqcvg_ctrl #(.MAX_QUADS(MAX_QUADS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  rqcvg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
